// ----- rtl/llwbs_pkg.sv -----
// shared types, codes and constants of the link line whitespace bit scanner
package llwbs_pkg;

  localparam int POSITION_WIDTH_DEFAULT = 32;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;

  // result queue geometry
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_LANE_SELECT    = 2'd0,
    REG_MIN_EACH_VALUE = 2'd1,
    REG_MIN_TOTAL      = 2'd2,
    REG_MINORITY_RATIO = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    LANE_PREFIX_PARITY = 2'd0,
    LANE_PREFIX_KIND   = 2'd1,
    LANE_SEP_PARITY    = 2'd2,
    LANE_SEP_KIND      = 2'd3
  } lane_t;

  typedef enum logic [1:0] {
    INFO_NONE  = 2'd0,
    INFO_SPACE = 2'd1,
    INFO_TAB   = 2'd2,
    INFO_MIXED = 2'd3
  } char_info_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_GT    = 8'h3E;

  localparam lane_t       LANE_RESET     = LANE_PREFIX_PARITY;
  localparam logic [15:0] MIN_EACH_RESET = 16'd8;
  localparam logic [15:0] MIN_TOTAL_RESET = 16'd32;
  localparam logic [7:0]  RATIO_RESET    = 8'd5;

  typedef struct packed {
    logic        result_kind;
    logic        bit_value;
    logic [31:0] item_offset;
    logic [31:0] item_length;
    logic [31:0] observation_total;
    logic        finding;
    logic [1:0]  report_status;
    logic        final_result;
  } result_t;

endpackage

// ----- rtl/llwbs_core.sv -----
// line parser, lane symbol extraction, counters and end report of the scanner
module llwbs_core #(
  parameter int POSITION_WIDTH = llwbs_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [llwbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [llwbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                 step,
  input  logic [7:0]                           data_byte,
  input  logic                                 end_of_stream,
  output logic [1:0]                           push_n,
  output llwbs_pkg::result_t                   res_a,
  output llwbs_pkg::result_t                   res_b
);
  import llwbs_pkg::*;

  localparam int PW = POSITION_WIDTH;

  typedef enum logic [2:0] {
    PH_START, PH_EQ, PH_PREFIX, PH_URL, PH_SEP, PH_LABEL, PH_REJECT
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [PW-1:0] line_begin;
    logic [PW-1:0] prefix_length;
    char_info_t prefix_info;
    logic [PW-1:0] url_end;
    logic [PW-1:0] sep_begin;
    logic [PW-1:0] sep_length;
    char_info_t sep_info;
  } line_t;

  typedef struct packed {
    logic          valid;
    logic          value;
    logic [PW-1:0] off;
    logic [PW-1:0] len;
  } sym_t;

  function automatic logic [PW-1:0] sat_inc(logic [PW-1:0] a);
    return (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic logic [PW-1:0] sat_sum(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PW] ? '1 : s[PW-1:0];
  endfunction

  function automatic logic [31:0] to32(logic [PW-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[31:0];
  endfunction

  function automatic logic is_hspace(logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

  function automatic char_info_t merge_info(char_info_t info, logic [7:0] c);
    char_info_t k;
    k = (c == CHAR_TAB) ? INFO_TAB : INFO_SPACE;
    if (info == INFO_NONE) return k;
    return (info == k) ? info : INFO_MIXED;
  endfunction

  function automatic line_t line_clear(logic [PW-1:0] start_pos);
    line_t r;
    r = '0;
    r.phase = PH_START;
    r.line_begin = start_pos;
    return r;
  endfunction

  function automatic line_t feed(line_t s, logic [7:0] c, logic [PW-1:0] p);
    line_t r;
    r = s;
    case (s.phase)
      PH_START: r.phase = (c == CHAR_EQ) ? PH_EQ : PH_REJECT;
      PH_EQ: begin
        if (c == CHAR_GT) begin
          r.phase = PH_PREFIX;
          r.prefix_length = '0;
          r.prefix_info = INFO_NONE;
        end else begin
          r.phase = PH_REJECT;
        end
      end
      PH_PREFIX: begin
        if (is_hspace(c)) begin
          r.prefix_length = sat_inc(s.prefix_length);
          r.prefix_info = merge_info(s.prefix_info, c);
        end else begin
          r.phase = PH_URL;
        end
      end
      PH_URL: begin
        if (is_hspace(c)) begin
          r.url_end = p;
          r.sep_begin = p;
          r.sep_length = PW'(1);
          r.sep_info = merge_info(INFO_NONE, c);
          r.phase = PH_SEP;
        end
      end
      PH_SEP: begin
        if (is_hspace(c)) begin
          r.sep_length = sat_inc(s.sep_length);
          r.sep_info = merge_info(s.sep_info, c);
        end else begin
          r.phase = PH_LABEL;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic sym_t close_line(line_t s, logic [PW-1:0] endp, lane_t lane);
    sym_t r;
    logic link;
    logic label;
    logic [PW-1:0] url_end;
    logic [PW-1:0] pstart;
    r = '0;
    link = (s.phase == PH_URL) || (s.phase == PH_LABEL);
    label = s.phase == PH_LABEL;
    url_end = (s.phase == PH_URL) ? endp : s.url_end;
    pstart = sat_sum(s.line_begin, PW'(2));
    if (link) begin
      case (lane)
        LANE_PREFIX_PARITY: begin
          r.valid = 1'b1;
          r.value = s.prefix_length[0];
          if (s.prefix_length != '0) begin
            r.off = pstart;
            r.len = s.prefix_length;
          end else begin
            // empty prefix: whole head of the line up to the url end
            r.off = s.line_begin;
            r.len = (url_end >= s.line_begin) ? url_end - s.line_begin : '0;
          end
        end
        LANE_PREFIX_KIND: begin
          if (s.prefix_length != '0 && (s.prefix_info inside {INFO_SPACE, INFO_TAB})) begin
            r.valid = 1'b1;
            r.off = pstart;
            r.len = s.prefix_length;
            r.value = s.prefix_info == INFO_TAB;
          end
        end
        LANE_SEP_PARITY: begin
          if (label) begin
            r.valid = 1'b1;
            r.off = s.sep_begin;
            r.len = s.sep_length;
            r.value = s.sep_length[0];
          end
        end
        default: begin
          if (label && (s.sep_info inside {INFO_SPACE, INFO_TAB})) begin
            r.valid = 1'b1;
            r.off = s.sep_begin;
            r.len = s.sep_length;
            r.value = s.sep_info == INFO_TAB;
          end
        end
      endcase
    end
    return r;
  endfunction

  // configuration
  lane_t       lane_select;
  logic [15:0] min_each_value;
  logic [15:0] min_total;
  logic [7:0]  minority_ratio;

  // stream state
  logic [PW-1:0] byte_position;
  line_t         line_st;
  logic          held_cr;
  logic [31:0]   zero_count;
  logic [31:0]   one_count;
  logic [PW-1:0] first_offset;
  logic [PW-1:0] end_offset;
  logic          overflow_flag;

  logic [PW-1:0] pos_after;
  logic [PW-1:0] pos_prev;
  logic          is_lf;
  logic          is_cr;
  logic          do_byte;
  line_t         line_cr;
  line_t         line_run;
  logic          held_next;
  logic          closing;
  line_t         close_in;
  logic [PW-1:0] close_endp;
  sym_t          sym;
  logic          emit;
  logic [31:0]   zero_next;
  logic [31:0]   one_next;
  logic [PW-1:0] first_next;
  logic [PW-1:0] end_next;
  logic          overflow_next;
  logic [32:0]   total;
  logic [31:0]   minority;
  logic [39:0]   product;
  logic [PW-1:0] span;
  status_t       status;
  logic          finding;
  result_t       sym_res;
  result_t       rep_res;

  assign pos_after = sat_inc(byte_position);
  assign pos_prev  = (byte_position == '0) ? '0 : byte_position - 1'b1;
  assign is_lf     = data_byte == CHAR_LF;
  assign is_cr     = data_byte == CHAR_CR;
  // a nul byte at a saturated position is not parsed
  assign do_byte   = !(byte_position == '1 && data_byte == CHAR_NUL);

  always_comb begin
    // a held cr not followed by lf is an ordinary byte of the line
    line_cr = held_cr ? feed(line_st, CHAR_CR, pos_prev) : line_st;
    line_run = line_cr;
    held_next = 1'b0;
    if (do_byte) begin
      if (is_cr) begin
        held_next = 1'b1;
      end else begin
        line_run = feed(line_cr, data_byte, byte_position);
      end
    end
  end

  // only one close per item can yield a symbol: lf closes the line, else end of stream
  assign closing    = is_lf || end_of_stream;
  assign close_in   = is_lf ? line_st : line_run;
  assign close_endp = is_lf ? (held_cr ? pos_prev : byte_position)
                            : (held_next ? byte_position : pos_after);
  assign sym        = close_line(close_in, close_endp, lane_select);

  always_comb begin
    zero_next = zero_count;
    one_next = one_count;
    first_next = first_offset;
    end_next = end_offset;
    overflow_next = overflow_flag;
    emit = 1'b0;
    if (closing && sym.valid && !overflow_flag) begin
      if (zero_count == '0 && one_count == '0) first_next = sym.off;
      if (sym.value ? (one_count == '1) : (zero_count == '1)) begin
        overflow_next = 1'b1;
      end else begin
        emit = 1'b1;
        if (sym.value) one_next = one_count + 1'b1;
        else zero_next = zero_count + 1'b1;
        end_next = sat_sum(sym.off, sym.len);
      end
    end
  end

  assign total    = {1'b0, zero_next} + {1'b0, one_next};
  assign minority = (zero_next < one_next) ? zero_next : one_next;
  assign product  = 40'(minority) * 40'(minority_ratio);
  assign span     = (end_next >= first_next) ? end_next - first_next : '0;
  assign status   = overflow_next ? STATUS_OVERFLOW
                  : (total == '0) ? STATUS_NONE : STATUS_OK;
  assign finding  = (status == STATUS_OK) && (zero_next >= 32'(min_each_value))
                  && (one_next >= 32'(min_each_value)) && (total >= 33'(min_total))
                  && (product >= 40'(total));

  always_comb begin
    sym_res = '0;
    sym_res.result_kind = KIND_SYMBOL;
    sym_res.bit_value = sym.value;
    sym_res.item_offset = to32(sym.off);
    sym_res.item_length = to32(sym.len);
    sym_res.report_status = STATUS_OK;
    sym_res.final_result = !end_of_stream;

    rep_res = '0;
    rep_res.result_kind = KIND_REPORT;
    rep_res.item_offset = to32(first_next);
    rep_res.item_length = to32(span);
    rep_res.observation_total = total[32] ? '1 : total[31:0];
    rep_res.finding = finding;
    rep_res.report_status = status;
    rep_res.final_result = 1'b1;
  end

  assign push_n = step ? (2'(emit) + 2'(end_of_stream)) : 2'd0;
  assign res_a  = emit ? sym_res : rep_res;
  assign res_b  = rep_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_select <= LANE_RESET;
      min_each_value <= MIN_EACH_RESET;
      min_total <= MIN_TOTAL_RESET;
      minority_ratio <= RATIO_RESET;
      byte_position <= '0;
      line_st <= line_clear('0);
      held_cr <= 1'b0;
      zero_count <= '0;
      one_count <= '0;
      first_offset <= '0;
      end_offset <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_LANE_SELECT:    lane_select <= lane_t'(cfg_data[1:0]);
          REG_MIN_EACH_VALUE: min_each_value <= cfg_data;
          REG_MIN_TOTAL:      min_total <= cfg_data;
          REG_MINORITY_RATIO: minority_ratio <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (step) begin
        if (end_of_stream) begin
          // report done, next byte opens a new stream
          byte_position <= '0;
          line_st <= line_clear('0);
          held_cr <= 1'b0;
          zero_count <= '0;
          one_count <= '0;
          first_offset <= '0;
          end_offset <= '0;
          overflow_flag <= 1'b0;
        end else begin
          byte_position <= pos_after;
          line_st <= is_lf ? line_clear(pos_after) : line_run;
          held_cr <= held_next;
          zero_count <= zero_next;
          one_count <= one_next;
          first_offset <= first_next;
          end_offset <= end_next;
          overflow_flag <= overflow_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (step && end_of_stream) |=> (byte_position == '0 && !held_cr && !overflow_flag))
    else $error("stream state not cleared after end of stream");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (zero_count == '1 || one_count == '1))
    else $error("overflow flag without a saturated count");

  a_held_cr_source: assert property (@(posedge clk) disable iff (rst)
    $rose(held_cr) |-> $past(step && data_byte == CHAR_CR))
    else $error("held cr set without an accepted cr");
`endif

endmodule

// ----- rtl/llwbs_rq.sv -----
// small result queue taking up to two results per cycle and giving one while out_ready is high
module llwbs_rq (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_n,
  input  llwbs_pkg::result_t push_a,
  input  llwbs_pkg::result_t push_b,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output llwbs_pkg::result_t head
);
  import llwbs_pkg::*;

  result_t          entry [RQ_DEPTH];
  logic [RQ_AW-1:0] wptr;
  logic [RQ_AW-1:0] rptr;
  logic [RQ_CW-1:0] count;
  logic             pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign head      = entry[rptr];
  // room for the two results that one item can cause
  assign room      = count <= RQ_CW'(RQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entry[wptr] <= push_a;
    if (push_n == 2'd2) entry[wptr + 1'b1] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + RQ_AW'(push_n);
      rptr <= rptr + RQ_AW'(pop);
      count <= count + RQ_CW'(push_n) - RQ_CW'(pop);
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= RQ_CW'(RQ_DEPTH))
    else $error("result queue over full");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push_n == 2'd0) |=> (count == $past(count) - 1'b1))
    else $error("result queue count wrong after pop");
`endif

endmodule

// ----- rtl/link_line_whitespace_bit_scanner.sv -----
// top level of the link line whitespace bit scanner
// a result is registered in the result queue before it is offered
// throughput: one byte per cycle while the queue has room; results leave one
// per cycle with out_ready high; a final byte closing a link line queues two
// reset: synchronous, clears stream state and queue, loads register defaults
module link_line_whitespace_bit_scanner #(
  parameter int POSITION_WIDTH = llwbs_pkg::POSITION_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [llwbs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [llwbs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            data_byte,
  input  logic                                  end_of_stream,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  result_kind,
  output logic                                  bit_value,
  output logic [31:0]                           item_offset,
  output logic [31:0]                           item_length,
  output logic [31:0]                           observation_total,
  output logic                                  finding,
  output logic [1:0]                            report_status,
  output logic                                  final_result
);
  import llwbs_pkg::*;

  logic       step;
  logic [1:0] push_n;
  result_t    res_a;
  result_t    res_b;
  result_t    head;
  logic       room;

  assign in_ready = room;
  assign step     = in_valid && in_ready;

  llwbs_core #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .step         (step),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .push_n       (push_n),
    .res_a        (res_a),
    .res_b        (res_b)
  );

  llwbs_rq u_rq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_a   (res_a),
    .push_b   (res_b),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign result_kind       = head.result_kind;
  assign bit_value         = head.bit_value;
  assign item_offset       = head.item_offset;
  assign item_length       = head.item_length;
  assign observation_total = head.observation_total;
  assign finding           = head.finding;
  assign report_status     = head.report_status;
  assign final_result      = head.final_result;

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the link line whitespace bit scanner
module testbench;
  import llwbs_pkg::*;

  localparam int LONG_HOLD_CYCLES = 60;
  localparam int SETTLE_CYCLES    = 4;

  typedef enum logic [2:0] {
    LS_START, LS_EQ, LS_PREFIX, LS_URL, LS_SEP, LS_LABEL, LS_REJECT
  } line_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       cfg_write = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_LANE_SELECT;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic [7:0]                 data_byte = CHAR_NUL;
  logic                       end_of_stream = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       result_kind;
  logic                       bit_value;
  logic [31:0]                item_offset;
  logic [31:0]                item_length;
  logic [31:0]                observation_total;
  logic                       finding;
  logic [1:0]                 report_status;
  logic                       final_result;

  link_line_whitespace_bit_scanner u_top (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .end_of_stream     (end_of_stream),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .result_kind       (result_kind),
    .bit_value         (bit_value),
    .item_offset       (item_offset),
    .item_length       (item_length),
    .observation_total (observation_total),
    .finding           (finding),
    .report_status     (report_status),
    .final_result      (final_result)
  );

  always #5 clk = ~clk;

  // registers as the scanner should hold them
  lane_t       cur_lane;
  logic [15:0] cur_min_each;
  logic [15:0] cur_min_total;
  logic [7:0]  cur_ratio;

  // stream and line state of the scanner
  line_state_t line_state;
  logic [31:0] scan_pos, line_base, lead_len, url_end, gap_start, sep_len;
  char_info_t  prefix_kind, sep_kind;
  logic        cr_pending, count_saturated;
  logic [31:0] zeros_seen, ones_seen, first_sym_off, last_sym_end;

  result_t step_out [2];
  int      step_n;
  result_t scan_results_due [$];
  result_t due_now;

  stream_byte_t bytes_to_send [$];
  int bytes_queued = 0;

  int send_idle_pct = 0, recv_idle_pct = 0;
  int send_gap = 0, stall_left = 0, hold_left = 0;
  int hold_requests = 0, holds_served = 0;
  int mismatch_count = 0, results_seen = 0;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic char_info_t merge_kind(input char_info_t info, input logic [7:0] c);
    char_info_t k;
    k = (c == CHAR_TAB) ? INFO_TAB : INFO_SPACE;
    if (info == INFO_NONE) return k;
    return (info == k) ? info : INFO_MIXED;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB;
  endfunction

  function automatic result_t make_result(input logic kind, input logic b,
                                          input logic [31:0] off, input logic [31:0] len,
                                          input logic [31:0] tot, input logic hit,
                                          input status_t status);
    result_t r;
    r.result_kind       = kind;
    r.bit_value         = b;
    r.item_offset       = off;
    r.item_length       = len;
    r.observation_total = tot;
    r.finding           = hit;
    r.report_status     = status;
    r.final_result      = 1'b0;
    return r;
  endfunction

  task automatic clear_line();
    line_state  = LS_START;
    lead_len    = '0;
    prefix_kind = INFO_NONE;
    url_end     = '0;
    gap_start   = '0;
    sep_len     = '0;
    sep_kind    = INFO_NONE;
  endtask

  task automatic clear_stream();
    clear_line();
    scan_pos        = '0;
    line_base       = '0;
    cr_pending      = 1'b0;
    zeros_seen      = '0;
    ones_seen       = '0;
    first_sym_off   = '0;
    last_sym_end    = '0;
    count_saturated = 1'b0;
  endtask

  task automatic reset_predictor();
    cur_lane      = LANE_RESET;
    cur_min_each  = MIN_EACH_RESET;
    cur_min_total = MIN_TOTAL_RESET;
    cur_ratio     = RATIO_RESET;
    clear_stream();
  endtask

  task automatic take_char(input logic [7:0] c, input logic [31:0] p);
    case (line_state)
      LS_START: line_state = (c == CHAR_EQ) ? LS_EQ : LS_REJECT;
      LS_EQ: begin
        if (c == CHAR_GT) begin
          line_state  = LS_PREFIX;
          lead_len    = '0;
          prefix_kind = INFO_NONE;
        end else begin
          line_state = LS_REJECT;
        end
      end
      LS_PREFIX: begin
        if (is_blank(c)) begin
          lead_len    = sat_add(lead_len, 32'd1);
          prefix_kind = merge_kind(prefix_kind, c);
        end else begin
          line_state = LS_URL;
        end
      end
      LS_URL: begin
        if (is_blank(c)) begin
          url_end    = p;
          gap_start  = p;
          sep_len    = 32'd1;
          sep_kind   = merge_kind(INFO_NONE, c);
          line_state = LS_SEP;
        end
      end
      LS_SEP: begin
        if (is_blank(c)) begin
          sep_len  = sat_add(sep_len, 32'd1);
          sep_kind = merge_kind(sep_kind, c);
        end else begin
          line_state = LS_LABEL;
        end
      end
      default: ;
    endcase
  endtask

  // line content ends before end_at; the next line begins at next_begin
  task automatic close_line(input logic [31:0] end_at, input logic [31:0] next_begin);
    logic        is_link, labeled, emit, b;
    logic [31:0] off, len, pstart;
    is_link = line_state == LS_URL || line_state == LS_LABEL;
    labeled = line_state == LS_LABEL;
    emit = 1'b0;
    b    = 1'b0;
    off  = '0;
    len  = '0;
    if (line_state == LS_URL) url_end = end_at;
    if (is_link) begin
      pstart = sat_add(line_base, 32'd2);
      case (cur_lane)
        LANE_PREFIX_PARITY: begin
          emit = 1'b1;
          b    = lead_len[0];
          if (lead_len != 0) begin
            off = pstart;
            len = lead_len;
          end else begin
            // empty prefix: the symbol runs from the line start to the url end
            off = line_base;
            len = (url_end >= line_base) ? url_end - line_base : 32'd0;
          end
        end
        LANE_PREFIX_KIND: begin
          if (lead_len != 0 && (prefix_kind == INFO_SPACE || prefix_kind == INFO_TAB)) begin
            emit = 1'b1;
            off  = pstart;
            len  = lead_len;
            b    = prefix_kind == INFO_TAB;
          end
        end
        LANE_SEP_PARITY: begin
          if (labeled) begin
            emit = 1'b1;
            off  = gap_start;
            len  = sep_len;
            b    = sep_len[0];
          end
        end
        default: begin
          if (labeled && (sep_kind == INFO_SPACE || sep_kind == INFO_TAB)) begin
            emit = 1'b1;
            off  = gap_start;
            len  = sep_len;
            b    = sep_kind == INFO_TAB;
          end
        end
      endcase
    end
    if (emit && !count_saturated) begin
      if (zeros_seen == 0 && ones_seen == 0) first_sym_off = off;
      if ((b ? ones_seen : zeros_seen) == '1) begin
        count_saturated = 1'b1;
      end else begin
        if (b) ones_seen++;
        else zeros_seen++;
        last_sym_end = sat_add(off, len);
        step_out[step_n] = make_result(KIND_SYMBOL, b, off, len, '0, 1'b0, STATUS_OK);
        step_n++;
      end
    end
    clear_line();
    line_base = next_begin;
  endtask

  // expected results of one accepted byte
  task automatic scan_byte(input logic [7:0] c, input logic eos);
    logic [31:0] here, next_pos, cr_at, span, tot_out, minority;
    logic [32:0] total;
    logic [40:0] weighted;
    logic        hit;
    status_t     status;
    step_n   = 0;
    here     = scan_pos;
    next_pos = sat_add(here, 32'd1);
    cr_at    = (here != 0) ? here - 32'd1 : 32'd0;
    if (cr_pending && c == CHAR_LF) begin
      cr_pending = 1'b0;
      close_line(cr_at, next_pos);
    end else begin
      // a held cr without lf behind it is an ordinary byte
      if (cr_pending) begin
        cr_pending = 1'b0;
        take_char(CHAR_CR, cr_at);
      end
      if (c == CHAR_LF) close_line(here, next_pos);
      else if (c == CHAR_CR) cr_pending = 1'b1;
      // a nul byte at a saturated position is not parsed
      else if (!(here == '1 && c == CHAR_NUL)) take_char(c, here);
    end
    scan_pos = next_pos;
    if (eos) begin
      // a cr as the very last byte is dropped from the line
      if (cr_pending) begin
        cr_pending = 1'b0;
        close_line(here, next_pos);
      end else begin
        close_line(next_pos, next_pos);
      end
      total    = {1'b0, zeros_seen} + {1'b0, ones_seen};
      minority = (zeros_seen < ones_seen) ? zeros_seen : ones_seen;
      weighted = {9'd0, minority} * {33'd0, cur_ratio};
      tot_out  = total[32] ? '1 : total[31:0];
      span     = (last_sym_end >= first_sym_off) ? last_sym_end - first_sym_off : 32'd0;
      if (count_saturated) status = STATUS_OVERFLOW;
      else if (total == 0) status = STATUS_NONE;
      else status = STATUS_OK;
      hit = status == STATUS_OK && zeros_seen >= cur_min_each && ones_seen >= cur_min_each &&
            total >= cur_min_total && weighted >= total;
      step_out[step_n] = make_result(KIND_REPORT, 1'b0, first_sym_off, span, tot_out, hit,
                                     status);
      step_n++;
      clear_stream();
    end
    if (step_n > 0) step_out[step_n-1].final_result = 1'b1;
    for (int i = 0; i < step_n; i++) scan_results_due.push_back(step_out[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("mismatch in %s of result %0d: got %0h, want %0h", what, results_seen, got,
               want);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        scan_byte(data_byte, end_of_stream);
        void'(bytes_to_send.pop_front());
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          in_valid      <= 1'b1;
          data_byte     <= bytes_to_send[0].data;
          end_of_stream <= bytes_to_send[0].eos;
        end
      end
    end
  end

  // result monitor and out_ready control
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (scan_results_due.size() == 0) begin
          report_mismatch("presence (nothing due)", '0, '0);
        end else begin
          due_now = scan_results_due.pop_front();
          if (result_kind !== due_now.result_kind)
            report_mismatch("result_kind", 32'(result_kind), 32'(due_now.result_kind));
          if (bit_value !== due_now.bit_value)
            report_mismatch("bit_value", 32'(bit_value), 32'(due_now.bit_value));
          if (item_offset !== due_now.item_offset)
            report_mismatch("item_offset", item_offset, due_now.item_offset);
          if (item_length !== due_now.item_length)
            report_mismatch("item_length", item_length, due_now.item_length);
          if (observation_total !== due_now.observation_total)
            report_mismatch("observation_total", observation_total,
                            due_now.observation_total);
          if (finding !== due_now.finding)
            report_mismatch("finding", 32'(finding), 32'(due_now.finding));
          if (report_status !== due_now.report_status)
            report_mismatch("report_status", 32'(report_status),
                            32'(due_now.report_status));
          if (final_result !== due_now.final_result)
            report_mismatch("final_result", 32'(final_result), 32'(due_now.final_result));
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served < hold_requests) begin
        holds_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 12);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) != 0) ? CHAR_TAB : CHAR_SPACE;
  endfunction

  // any byte that can stand in a url
  function automatic logic [7:0] url_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_blank(c) || c == CHAR_LF);
    return c;
  endfunction

  function automatic logic [7:0] label_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
    return c;
  endfunction

  task automatic send_text(input logic [7:0] text[$], input bit eos_last);
    stream_byte_t sb;
    foreach (text[i]) begin
      sb.data = text[i];
      sb.eos  = eos_last && (i == text.size() - 1);
      bytes_to_send.push_back(sb);
      bytes_queued++;
    end
  endtask

  // the last line of a stream may end in lf, crlf, a lone cr or nothing at all
  task automatic finish_line(input logic [7:0] text[$], input bit last);
    case ($urandom_range(0, 3))
      0: text.push_back(CHAR_LF);
      1: begin
        text.push_back(CHAR_CR);
        text.push_back(CHAR_LF);
      end
      2: text.push_back(last ? CHAR_CR : CHAR_LF);
      default: if (!last) text.push_back(CHAR_LF);
    endcase
    if (text.size() == 0) text.push_back(label_char());
    send_text(text, last);
  endtask

  task automatic queue_link_line(input bit last);
    logic [7:0] text[$];
    logic [7:0] k;
    bit         uniform;
    int         shape;
    text = '{CHAR_EQ, CHAR_GT};
    uniform = 1'($urandom_range(0, 1));
    k = blank_char();
    repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4))
      text.push_back(uniform ? k : blank_char());
    repeat ($urandom_range(1, 4)) text.push_back(url_char());
    // 0 bare url, 3 separator without label
    shape = $urandom_range(0, 3);
    if (shape != 0) begin
      uniform = 1'($urandom_range(0, 1));
      k = blank_char();
      repeat ($urandom_range(1, 4)) text.push_back(uniform ? k : blank_char());
      if (shape != 3) repeat ($urandom_range(1, 4)) text.push_back(label_char());
    end
    finish_line(text, last);
  endtask

  task automatic queue_noise_line(input bit last);
    logic [7:0] text[$];
    logic [7:0] pick[$];
    pick = '{CHAR_EQ, CHAR_GT, CHAR_SPACE, CHAR_TAB, CHAR_CR};
    case ($urandom_range(0, 2))
      1: text.push_back(CHAR_EQ);
      2: text = '{CHAR_EQ, CHAR_GT};
      default: ;
    endcase
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 2) == 0) text.push_back(label_char());
      else text.push_back(pick[$urandom_range(0, 4)]);
    end
    finish_line(text, last);
  endtask

  task automatic queue_streams(input int budget);
    int goal, lines;
    bit closing;
    goal = bytes_queued + budget;
    while (bytes_queued < goal) begin
      lines = $urandom_range(1, 10);
      for (int i = 0; i < lines; i++) begin
        // end the stream early once the byte budget is nearly spent
        closing = (i == lines - 1) || (bytes_queued + 10 >= goal);
        if ($urandom_range(0, 99) < 20) queue_noise_line(closing);
        else queue_link_line(closing);
        if (closing) break;
      end
    end
  endtask

  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || scan_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LANE_SELECT:    cur_lane = lane_t'(v[1:0]);
      REG_MIN_EACH_VALUE: cur_min_each = v;
      REG_MIN_TOTAL:      cur_min_total = v;
      default:            cur_ratio = v[7:0];
    endcase
  endtask

  task automatic run_phase(input lane_t lane, input logic [15:0] min_each,
                           input logic [15:0] min_tot, input logic [7:0] ratio,
                           input int budget, input int send_pct, input int recv_pct);
    wait_idle();
    write_reg(REG_LANE_SELECT, {14'd0, lane});
    write_reg(REG_MIN_EACH_VALUE, min_each);
    write_reg(REG_MIN_TOTAL, min_tot);
    write_reg(REG_MINORITY_RATIO, {8'd0, ratio});
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_streams(budget);
  endtask

  initial begin
    logic [7:0] seq[$];
    reset_predictor();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // stream of one nul byte: no symbols at all
    seq = '{CHAR_NUL};
    send_text(seq, 1'b1);
    // space prefix closed by crlf
    seq = '{CHAR_EQ, CHAR_GT, CHAR_SPACE, "a", CHAR_CR, CHAR_LF};
    send_text(seq, 1'b0);
    // stray cr inside the url, then separator and label
    seq = '{CHAR_EQ, CHAR_GT, CHAR_TAB, "b", CHAR_CR, "c", CHAR_SPACE, "x", CHAR_LF};
    send_text(seq, 1'b0);
    // separator without a label is no link
    seq = '{CHAR_EQ, CHAR_GT, "x", CHAR_SPACE, CHAR_LF};
    send_text(seq, 1'b0);
    // cr as the last byte of the stream
    seq = '{CHAR_EQ, CHAR_GT, "y", CHAR_CR};
    send_text(seq, 1'b1);
    seq = '{8'hFF};
    send_text(seq, 1'b1);

    run_phase(LANE_RESET, MIN_EACH_RESET, MIN_TOTAL_RESET, RATIO_RESET, 80, 15, 15);
    run_phase(LANE_PREFIX_KIND, 16'd0, 16'd0, 8'd4, 80, 20, 20);
    run_phase(LANE_SEP_PARITY, 16'd2, 16'd6, 8'd3, 80, 0, 30);
    run_phase(LANE_SEP_KIND, 16'hFFFF, 16'hFFFF, 8'hFF, 70, 30, 0);
    run_phase(LANE_SEP_PARITY, 16'd0, 16'd0, 8'd0, 60, 10, 10);
    run_phase(LANE_PREFIX_PARITY, 16'd1, 16'd3, 8'd1, 80, 25, 25);

    // long receiver hold while bytes keep coming: short streams, two results each (one if the url byte is a cr)
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (20) begin
      seq = '{CHAR_EQ, CHAR_GT, url_char()};
      send_text(seq, 1'b1);
    end

    repeat (2)
      run_phase(lane_t'($urandom_range(0, 3)), 16'($urandom_range(0, 6)),
                16'($urandom_range(0, 20)), 8'($urandom_range(1, 255)), 55, 20, 20);
    run_phase(lane_t'($urandom_range(0, 3)), 16'($urandom_range(0, 4)),
              16'($urandom_range(0, 12)), 8'($urandom_range(2, 8)), 55, 0, 0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
